>>> rtl/bfa_pkg.sv
// shared types and constants of the best-fit block allocator
`default_nettype none
package bfa_pkg;

  localparam int DEF_NUM_BLOCKS = 16;
  localparam int DEF_SIZE_BITS  = 16;
  localparam int CFG_W          = 5;
  localparam int SLOT_W         = 4;
  localparam int FIELD_SIZE_W   = 16;
  localparam int SUM_W          = 32;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic [SLOT_W-1:0]       block_slot;
    logic [FIELD_SIZE_W-1:0] size_value;
  } item_beat_t;

  typedef struct packed {
    logic                    granted;
    logic [SLOT_W-1:0]       chosen_block;
    logic [FIELD_SIZE_W-1:0] leftover_size;
    logic [SUM_W-1:0]        internal_total;
    logic [SUM_W-1:0]        external_total;
  } result_beat_t;

  typedef struct packed {
    logic valid;
    logic found;
  } cand_flags_t;

endpackage
`default_nettype wire

>>> rtl/bfa_cell.sv
// one table entry and one stage of the best-fit search chain
`default_nettype none
module bfa_cell #(
  parameter int NUM_BLOCKS = bfa_pkg::DEF_NUM_BLOCKS,
  parameter int SIZE_BITS  = bfa_pkg::DEF_SIZE_BITS,
  parameter int INDEX      = 0,
  localparam int IDX_W     = $clog2(NUM_BLOCKS),
  localparam int AW        = (IDX_W > bfa_pkg::SLOT_W) ? IDX_W : bfa_pkg::SLOT_W
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [bfa_pkg::CFG_W-1:0] cfg_limit,
  input  wire logic [SIZE_BITS-1:0]      req_size,
  input  wire logic                      wr_en,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic [SIZE_BITS-1:0]      wr_data,
  input  wire bfa_pkg::cand_flags_t      cand_in_flags,
  input  wire logic [IDX_W-1:0]          cand_in_idx,
  input  wire logic [SIZE_BITS-1:0]      cand_in_left,
  output bfa_pkg::cand_flags_t           cand_out_flags,
  output logic [IDX_W-1:0]               cand_out_idx,
  output logic [SIZE_BITS-1:0]           cand_out_left
);
  import bfa_pkg::*;

  localparam int LW = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;

  logic [SIZE_BITS-1:0] entry;
  logic                 in_range;
  logic                 fits;
  logic                 take;
  logic [SIZE_BITS-1:0] left_self;

  assign in_range  = LW'(INDEX) < LW'(cfg_limit);
  assign left_self = entry - req_size;
  assign fits      = cand_in_flags.valid && in_range && (entry >= req_size);
  assign take      = fits && (!cand_in_flags.found || (left_self < cand_in_left));

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (wr_en && (wr_addr == AW'(INDEX))) begin
      entry <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out_flags <= '0;
    end else begin
      cand_out_flags.valid <= cand_in_flags.valid;
      cand_out_flags.found <= cand_in_flags.found || take;
    end
  end

  always_ff @(posedge clk) begin
    cand_out_idx  <= take ? IDX_W'(INDEX) : cand_in_idx;
    cand_out_left <= take ? left_self : cand_in_left;
  end

endmodule
`default_nettype wire

>>> rtl/best_fit_block_allocator_top.sv
// top level of the best-fit block allocator: control, totals and the cell chain
//
//  channel   direction  handshake               payload
//  item      in         item_valid/item_ready   bfa_pkg::item_beat_t
//  result    out        result_valid/result_ready bfa_pkg::result_beat_t
//  cfg       in         cfg_we (no wait)        blocks_in_use, 5 bits
//
//  a load beat writes its entry straight into the cell
//  a request walks a candidate down the chain of NUM_BLOCKS cells, one cell a
//  cycle, then the finish step updates the entry and totals
//  one item is in flight at a time
//  a result held downstream stalls the next request in its finish step; items
//  are taken whenever the control is idle
//  synchronous reset clears the table, totals, count and all valids
`default_nettype none
module best_fit_block_allocator_top #(
  parameter int NUM_BLOCKS = bfa_pkg::DEF_NUM_BLOCKS,
  parameter int SIZE_BITS  = bfa_pkg::DEF_SIZE_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      item_valid,
  output logic                           item_ready,
  input  wire bfa_pkg::item_beat_t       item,
  output logic                           result_valid,
  input  wire logic                      result_ready,
  output bfa_pkg::result_beat_t          result,
  input  wire logic                      cfg_we,
  input  wire logic [bfa_pkg::CFG_W-1:0] cfg_wdata
);
  import bfa_pkg::*;

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int AW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]           state;
  logic [CFG_W-1:0]     blocks_in_use;
  logic [SIZE_BITS-1:0] size_q;
  logic                 start;
  logic [SUM_W-1:0]     int_sum;
  logic [SUM_W-1:0]     ext_sum;
  logic                 fin_found;
  logic [IDX_W-1:0]     fin_idx;
  logic [SIZE_BITS-1:0] fin_left;

  cand_flags_t          flags_chain [NUM_BLOCKS+1];
  logic [IDX_W-1:0]     idx_chain   [NUM_BLOCKS+1];
  logic [SIZE_BITS-1:0] left_chain  [NUM_BLOCKS+1];

  logic                        item_acc;
  logic                        finish_go;
  logic [SIZE_BITS+FIELD_SIZE_W-1:0] size_ext;
  logic [SIZE_BITS-1:0]        item_size;
  logic [AW+SLOT_W-1:0]        slot_ext;
  logic [AW+IDX_W-1:0]         fin_idx_ext;
  logic [IDX_W+SLOT_W-1:0]     chosen_ext;
  logic [SIZE_BITS+FIELD_SIZE_W-1:0] left_ext;
  logic [SIZE_BITS+SUM_W-1:0]  left_wide;
  logic [SIZE_BITS+SUM_W-1:0]  size_wide;
  logic [SUM_W:0]              int_add;
  logic [SUM_W:0]              ext_add;
  logic [SUM_W-1:0]            int_sat;
  logic [SUM_W-1:0]            ext_sat;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [SIZE_BITS-1:0] wr_data;

  assign item_ready = (state == ST_IDLE);
  assign item_acc   = item_valid && item_ready;
  assign finish_go  = (state == ST_FINISH) && (!result_valid || result_ready);

  assign size_ext    = {{SIZE_BITS{1'b0}}, item.size_value};
  assign item_size   = size_ext[SIZE_BITS-1:0];
  assign slot_ext    = {{AW{1'b0}}, item.block_slot};
  assign fin_idx_ext = {{AW{1'b0}}, fin_idx};
  assign chosen_ext  = {{SLOT_W{1'b0}}, fin_idx};
  assign left_ext    = {{FIELD_SIZE_W{1'b0}}, fin_left};
  assign left_wide   = {{SUM_W{1'b0}}, fin_left};
  assign size_wide   = {{SUM_W{1'b0}}, size_q};

  assign int_add = {1'b0, int_sum} + {1'b0, left_wide[SUM_W-1:0]};
  assign ext_add = {1'b0, ext_sum} + {1'b0, size_wide[SUM_W-1:0]};
  assign int_sat = int_add[SUM_W] ? {SUM_W{1'b1}} : int_add[SUM_W-1:0];
  assign ext_sat = ext_add[SUM_W] ? {SUM_W{1'b1}} : ext_add[SUM_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_ext[AW-1:0];
    wr_data = item_size;
    priority if (item_acc && (item.kind == KIND_LOAD)) begin
      wr_en = 1'b1;
    end else if (finish_go && fin_found) begin
      wr_en   = 1'b1;
      wr_addr = fin_idx_ext[AW-1:0];
      wr_data = fin_left;
    end
  end

  // candidate enters the chain empty
  assign flags_chain[0] = '{valid: start, found: 1'b0};
  assign idx_chain[0]   = '0;
  assign left_chain[0]  = '0;

  for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
    bfa_cell #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS),
      .INDEX      (g)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .cfg_limit      (blocks_in_use),
      .req_size       (size_q),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .cand_in_flags  (flags_chain[g]),
      .cand_in_idx    (idx_chain[g]),
      .cand_in_left   (left_chain[g]),
      .cand_out_flags (flags_chain[g+1]),
      .cand_out_idx   (idx_chain[g+1]),
      .cand_out_left  (left_chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= '0;
    end else if (cfg_we) begin
      blocks_in_use <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      start        <= 1'b0;
      int_sum      <= '0;
      ext_sum      <= '0;
      result_valid <= 1'b0;
    end else begin
      start <= item_acc && (item.kind == KIND_REQUEST);
      if (finish_go) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_acc && (item.kind == KIND_REQUEST)) begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (flags_chain[NUM_BLOCKS].valid) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (finish_go) begin
            state <= ST_IDLE;
            if (fin_found) begin
              int_sum <= int_sat;
            end else begin
              ext_sum <= ext_sat;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc && (item.kind == KIND_REQUEST)) begin
      size_q <= item_size;
    end
    if ((state == ST_SEARCH) && flags_chain[NUM_BLOCKS].valid) begin
      fin_found <= flags_chain[NUM_BLOCKS].found;
      fin_idx   <= idx_chain[NUM_BLOCKS];
      fin_left  <= left_chain[NUM_BLOCKS];
    end
    if (finish_go) begin
      result.granted        <= fin_found;
      result.chosen_block   <= fin_found ? chosen_ext[SLOT_W-1:0] : '0;
      result.leftover_size  <= fin_found ? left_ext[FIELD_SIZE_W-1:0] : '0;
      result.internal_total <= fin_found ? int_sat : int_sum;
      result.external_total <= fin_found ? ext_sum : ext_sat;
    end
  end

endmodule
`default_nettype wire

>>> rtl/bfa_checker.sv
// port-level checks of the best-fit block allocator and their binding
`default_nettype none
module bfa_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      item_valid,
  input wire logic                      item_ready,
  input wire bfa_pkg::item_beat_t       item,
  input wire logic                      result_valid,
  input wire logic                      result_ready,
  input wire bfa_pkg::result_beat_t     result
);
  import bfa_pkg::*;

  // a waiting result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.granted |-> result.chosen_block == '0 && result.leftover_size == '0)
    else $error("refused request with non-zero block or leftover");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_request_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.kind == KIND_REQUEST |=> !item_ready)
    else $error("item taken during a search");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.kind == KIND_LOAD && !result_valid |=> !result_valid)
    else $error("load beat produced a result");

endmodule

bind best_fit_block_allocator_top bfa_checker u_bfa_checker (.*);
`default_nettype wire

>>> tb/best_fit_block_allocator_top_tb.sv
// self-checking testbench of the best-fit block allocator: directed and random beats, scoreboard
`default_nettype none
module best_fit_block_allocator_top_tb;
  import bfa_pkg::*;

  localparam int TABLE_DEPTH   = 16;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 4000;

  class alloc_scoreboard;
    logic [FIELD_SIZE_W-1:0] free_size [TABLE_DEPTH];
    logic [SUM_W-1:0]        internal_sum;
    logic [SUM_W-1:0]        external_sum;
    logic [CFG_W-1:0]        blocks_in_use;
    result_beat_t            outcomes_due [$];
    int                      errors;

    function new();
      foreach (free_size[i]) free_size[i] = '0;
      internal_sum  = '0;
      external_sum  = '0;
      blocks_in_use = '0;
      errors        = 0;
    endfunction

    function void set_blocks(logic [CFG_W-1:0] v);
      blocks_in_use = v;
    endfunction

    function int outstanding();
      return outcomes_due.size();
    endfunction

    function logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] acc, logic [FIELD_SIZE_W-1:0] add);
      logic [SUM_W:0] s;
      s = {1'b0, acc} + {{(SUM_W-FIELD_SIZE_W+1){1'b0}}, add};
      return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    function void note_item(item_beat_t b);
      result_beat_t            r;
      int                      limit;
      bit                      found;
      logic [FIELD_SIZE_W-1:0] left;
      logic [FIELD_SIZE_W-1:0] best_left;
      logic [SLOT_W-1:0]       best_idx;
      if (b.kind == KIND_LOAD) begin
        free_size[b.block_slot] = b.size_value;
        return;
      end
      limit = (blocks_in_use > TABLE_DEPTH) ? TABLE_DEPTH : int'(blocks_in_use);
      found = 1'b0;
      best_left = '0;
      best_idx = '0;
      for (int j = 0; j < limit; j++) begin
        if (free_size[j] >= b.size_value) begin
          left = free_size[j] - b.size_value;
          if (!found || left < best_left) begin
            found = 1'b1;
            best_idx = SLOT_W'(j);
            best_left = left;
          end
        end
      end
      r = '0;
      if (found) begin
        free_size[best_idx] = best_left;
        internal_sum = sat_add(internal_sum, best_left);
        r.granted = 1'b1;
        r.chosen_block = best_idx;
        r.leftover_size = best_left;
      end else begin
        external_sum = sat_add(external_sum, b.size_value);
      end
      r.internal_total = internal_sum;
      r.external_total = external_sum;
      outcomes_due.push_back(r);
    endfunction

    function void cmp_field(string name, logic [SUM_W-1:0] want, logic [SUM_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_beat_t got);
      result_beat_t want;
      if (outcomes_due.size() == 0) begin
        $error("result beat with no request waiting: %p", got);
        errors++;
        return;
      end
      want = outcomes_due.pop_front();
      cmp_field("granted", SUM_W'(want.granted), SUM_W'(got.granted));
      cmp_field("chosen_block", SUM_W'(want.chosen_block), SUM_W'(got.chosen_block));
      cmp_field("leftover_size", SUM_W'(want.leftover_size), SUM_W'(got.leftover_size));
      cmp_field("internal_total", want.internal_total, got.internal_total);
      cmp_field("external_total", want.external_total, got.external_total);
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    item_valid;
  logic                    item_ready;
  item_beat_t              item;
  logic                    result_valid;
  logic                    result_ready;
  result_beat_t            result;
  logic                    cfg_we;
  logic [CFG_W-1:0]        cfg_wdata;

  alloc_scoreboard         sb;
  bit                      steady;
  bit                      hold_off_req;
  logic [FIELD_SIZE_W-1:0] last_load;

  best_fit_block_allocator_top DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: random ready, steady stretches and one long hold-off
  initial begin : result_sink
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        result_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (steady) result_ready = 1'b1;
      else result_ready = ($urandom_range(99) >= 37);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  task automatic send_item(input logic k, input logic [SLOT_W-1:0] slot,
                           input logic [FIELD_SIZE_W-1:0] sz);
    item_beat_t b;
    b.kind = k;
    b.block_slot = slot;
    b.size_value = sz;
    while (!steady && $urandom_range(99) < 37) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    item = b;
    do @(posedge clk); while (!item_ready);
    sb.note_item(b);
    @(negedge clk);
  endtask

  task automatic settle();
    item_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_blocks(input logic [CFG_W-1:0] v);
    settle();
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_blocks(v);
  endtask

  task automatic send_random_item();
    logic [FIELD_SIZE_W-1:0] sz;
    logic [SLOT_W-1:0]       slot;
    int                      pick;
    slot = SLOT_W'($urandom_range(15, 0));
    pick = $urandom_range(99);
    if ($urandom_range(99) < 40) begin
      if (pick < 10) sz = '1;
      else if (pick < 20) sz = '0;
      else sz = FIELD_SIZE_W'($urandom);
      last_load = sz;
      send_item(KIND_LOAD, slot, sz);
    end else begin
      if (pick < 30) sz = FIELD_SIZE_W'($urandom_range(255));
      else if (pick < 70) sz = FIELD_SIZE_W'($urandom_range(last_load));
      else if (pick < 90) sz = FIELD_SIZE_W'($urandom);
      else sz = pick[0] ? '1 : '0;
      send_item(KIND_REQUEST, slot, sz);
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] blocks, input int count);
    write_blocks(blocks);
    repeat (count) send_random_item();
  endtask

  initial begin : main
    sb = new();
    steady = 1'b0;
    hold_off_req = 1'b0;
    last_load = '1;
    item_valid = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rst = 1'b1;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // empty search straight after reset
    send_item(KIND_REQUEST, 4'h0, 16'h0000);
    send_item(KIND_REQUEST, 4'hF, 16'hFFFF);

    write_blocks(5'd16);
    send_item(KIND_LOAD, 4'h0, 16'hFFFF);
    send_item(KIND_LOAD, 4'hF, 16'h0000);
    send_item(KIND_LOAD, 4'h3, 16'd100);
    send_item(KIND_LOAD, 4'h7, 16'd100);
    send_item(KIND_LOAD, 4'h9, 16'd50);
    // zero-size request, then a tie, then best fit and the largest size
    send_item(KIND_REQUEST, 4'h5, 16'h0000);
    send_item(KIND_REQUEST, 4'h0, 16'd100);
    send_item(KIND_REQUEST, 4'hA, 16'd100);
    send_item(KIND_REQUEST, 4'h0, 16'd40);
    send_item(KIND_REQUEST, 4'h0, 16'hFFFF);
    send_item(KIND_REQUEST, 4'h0, 16'd1);
    send_item(KIND_REQUEST, 4'hF, 16'hFFFF);

    // search count beyond the table
    write_blocks(5'd31);
    send_item(KIND_LOAD, 4'hF, 16'hFFFF);
    send_item(KIND_REQUEST, 4'h0, 16'hFFFE);
    send_item(KIND_REQUEST, 4'h3, 16'h0001);

    // single block in the search
    write_blocks(5'd1);
    send_item(KIND_LOAD, 4'h0, 16'd500);
    send_item(KIND_LOAD, 4'h1, 16'd10);
    send_item(KIND_REQUEST, 4'h1, 16'd10);
    send_item(KIND_REQUEST, 4'h1, 16'd491);

    run_phase(5'd16, 130);
    steady = 1'b1;
    run_phase(CFG_W'($urandom_range(15, 1)), 130);
    steady = 1'b0;
    hold_off_req = 1'b1;
    run_phase(5'd16, 130);
    run_phase(5'd0, 100);
    run_phase(5'd31, 130);
    run_phase(5'd2, 130);
    run_phase(CFG_W'($urandom_range(31, 17)), 130);

    item_valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire

>>> best_fit_block_allocator_top.f
rtl/bfa_pkg.sv
rtl/bfa_cell.sv
rtl/best_fit_block_allocator_top.sv
rtl/bfa_checker.sv
tb/best_fit_block_allocator_top_tb.sv
